@@ src/baro_ptc_pkg.sv @@
// Shared types and constants for the barometric pressure compensation pipeline.
// No dependencies; the design files refer to it by scoped names, the testbench files import it.
package baro_ptc_pkg;

  localparam int NSTAGE = 8;

  localparam int COEF_W  = 16;
  localparam int RAW_W   = 24;
  localparam int PRESS_W = 20;
  localparam int TEMP_W  = 19;
  localparam int DT_W    = 25;
  localparam int PROD_W  = 42;
  localparam int SUM_W   = 40;
  localparam int SQ_W    = 35;
  localparam int ADDR_W  = 3;

  typedef logic [ADDR_W-1:0] reg_idx_t;

  localparam reg_idx_t REG_SENS     = 3'd0;
  localparam reg_idx_t REG_OFF      = 3'd1;
  localparam reg_idx_t REG_TCS      = 3'd2;
  localparam reg_idx_t REG_TCO      = 3'd3;
  localparam reg_idx_t REG_TREF     = 3'd4;
  localparam reg_idx_t REG_TEMPSENS = 3'd5;

  typedef struct packed {
    logic [COEF_W-1:0] sens;
    logic [COEF_W-1:0] off;
    logic [COEF_W-1:0] tcs;
    logic [COEF_W-1:0] tco;
    logic [COEF_W-1:0] tref;
    logic [COEF_W-1:0] tempsens;
  } coef_t;

  // Temperature thresholds in hundredths of a degree
  localparam logic signed [TEMP_W-1:0] TEMP_REF = 19'sd2000;
  localparam logic signed [TEMP_W-1:0] TEMP_LOW = -19'sd1500;
  localparam logic signed [TEMP_W-1:0] TEMP_MIN = -19'sd129070;
  localparam logic signed [TEMP_W-1:0] TEMP_MAX = 19'sd133070;

  localparam logic [PRESS_W-1:0] PRESS_MAX = '1;

endpackage

@@ src/baro_pressure_temp_compensation_unit.sv @@
// Top level of the barometric pressure and temperature compensation pipeline.
// Depends on baro_ptc_pkg, baro_ptc_flow, baro_ptc_front, baro_ptc_corr, baro_ptc_press.
//
//   channel | direction | beat contents
//   --------+-----------+-------------------------------------------------
//   in_*    | sink      | raw pressure D1, raw temperature D2
//   out_*   | source    | compensated pressure, temperature (0.01 degC)
//   cfg_*   | sink      | write of one of six 16-bit calibration coefficients
//
// One beat per cycle in and out while the output is not stalled; each beat passes
// through eight register stages (dT, products, OFF/SENS/TEMP, squares, corrections,
// split D1*SENS product, product sum, scale and clamp).
// rst_n clears the stage valid bits and the coefficients; data registers keep
// whatever they hold. A stall at the output freezes full stages and lets
// bubbles ahead of it fill, so no beat is lost or repeated.
module baro_pressure_temp_compensation_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [47:0]                        in_tdata,   // [23:0] raw_pressure, [47:24] raw_temperature
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [39:0]                        out_tdata,  // [19:0] pressure, [38:20] temperature, [39] zero
  input  logic                               cfg_wr_en,
  input  logic [baro_ptc_pkg::ADDR_W-1:0]    cfg_addr,
  input  logic [baro_ptc_pkg::COEF_W-1:0]    cfg_wdata
);

  localparam int RW = baro_ptc_pkg::RAW_W;
  localparam int SW = baro_ptc_pkg::SUM_W;
  localparam int TW = baro_ptc_pkg::TEMP_W;
  localparam int PW = baro_ptc_pkg::PRESS_W;

  baro_ptc_pkg::coef_t coef_r, coef_nxt;

  logic [baro_ptc_pkg::NSTAGE-1:0] en;

  logic [RW-1:0]        d1_a, d1_b;
  logic signed [SW-1:0] off0, sens0, off, sens;
  logic signed [TW-1:0] temp_a, temp_b, temperature;
  logic [PW-1:0]        pressure;

  always_comb begin
    coef_nxt = coef_r;
    if (cfg_wr_en) begin
      unique case (cfg_addr)
        baro_ptc_pkg::REG_SENS:     coef_nxt.sens     = cfg_wdata;
        baro_ptc_pkg::REG_OFF:      coef_nxt.off      = cfg_wdata;
        baro_ptc_pkg::REG_TCS:      coef_nxt.tcs      = cfg_wdata;
        baro_ptc_pkg::REG_TCO:      coef_nxt.tco      = cfg_wdata;
        baro_ptc_pkg::REG_TREF:     coef_nxt.tref     = cfg_wdata;
        baro_ptc_pkg::REG_TEMPSENS: coef_nxt.tempsens = cfg_wdata;
        default:                    coef_nxt          = coef_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r <= '0;
    end else begin
      coef_r <= coef_nxt;
    end
  end

  baro_ptc_flow u_flow (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .en         (en)
  );

  baro_ptc_front u_front (
    .clk             (clk),
    .en              (en[2:0]),
    .coef            (coef_r),
    .raw_pressure    (in_tdata[23:0]),
    .raw_temperature (in_tdata[47:24]),
    .d1              (d1_a),
    .off0            (off0),
    .sens0           (sens0),
    .temp            (temp_a)
  );

  baro_ptc_corr u_corr (
    .clk      (clk),
    .en       (en[4:3]),
    .d1_in    (d1_a),
    .off0     (off0),
    .sens0    (sens0),
    .temp_in  (temp_a),
    .d1_out   (d1_b),
    .off      (off),
    .sens     (sens),
    .temp_out (temp_b)
  );

  baro_ptc_press u_press (
    .clk         (clk),
    .en          (en[7:5]),
    .d1          (d1_b),
    .off         (off),
    .sens        (sens),
    .temp_in     (temp_b),
    .pressure    (pressure),
    .temperature (temperature)
  );

  assign out_tdata = {1'b0, temperature, pressure};

  a_temp_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (($signed(out_tdata[38:20]) >= baro_ptc_pkg::TEMP_MIN) &&
                    ($signed(out_tdata[38:20]) <= baro_ptc_pkg::TEMP_MAX)))
    else $error("temperature outside the reachable range");

  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !out_tdata[39])
    else $error("output pad bit set");

endmodule

@@ src/baro_ptc_flow.sv @@
// Valid bits and stall chain for the compensation pipeline.
// Uses baro_ptc_pkg for the stage count.
module baro_ptc_flow (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [baro_ptc_pkg::NSTAGE-1:0]  en
);

  localparam int N = baro_ptc_pkg::NSTAGE;

  logic [N-1:0] valid_r;
  logic [N-1:0] valid_nxt;

  // A stage may load when it is empty or the stage after it moves.
  always_comb begin
    en[N-1] = !valid_r[N-1] || out_tready;
    for (int k = N - 2; k >= 0; k--) begin
      en[k] = !valid_r[k] || en[k+1];
    end
  end

  assign valid_nxt = {valid_r[N-2:0], in_tvalid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= (valid_nxt & en) | (valid_r & ~en);
    end
  end

  assign in_tready  = en[0];
  assign out_tvalid = valid_r[N-1];

  a_full_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> ((&valid_r) && !out_tready))
    else $error("input blocked while pipeline has a bubble");

  a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> valid_r[0])
    else $error("accepted beat missing from first stage");

  a_out_from_prev: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(valid_r[N-1]) |-> $past(valid_r[N-2]))
    else $error("output valid rose without a beat behind it");

endmodule

@@ src/baro_ptc_front.sv @@
// Stages 1-3: temperature difference, first-order products, OFF, SENS, TEMP.
// Uses baro_ptc_pkg for widths, thresholds and the coefficient struct.
module baro_ptc_front (
  input  logic                                     clk,
  input  logic [2:0]                               en,
  input  baro_ptc_pkg::coef_t                      coef,
  input  logic [baro_ptc_pkg::RAW_W-1:0]           raw_pressure,
  input  logic [baro_ptc_pkg::RAW_W-1:0]           raw_temperature,
  output logic [baro_ptc_pkg::RAW_W-1:0]           d1,
  output logic signed [baro_ptc_pkg::SUM_W-1:0]    off0,
  output logic signed [baro_ptc_pkg::SUM_W-1:0]    sens0,
  output logic signed [baro_ptc_pkg::TEMP_W-1:0]   temp
);

  localparam int RW = baro_ptc_pkg::RAW_W;
  localparam int DW = baro_ptc_pkg::DT_W;
  localparam int PW = baro_ptc_pkg::PROD_W;
  localparam int SW = baro_ptc_pkg::SUM_W;
  localparam int TW = baro_ptc_pkg::TEMP_W;

  logic [RW-1:0]        d1_s1_r, d1_s2_r, d1_s3_r;
  logic signed [DW-1:0] dt_r, dt_nxt;
  logic signed [PW-1:0] p_off_r, p_sens_r, p_temp_r;
  logic signed [PW-1:0] p_off_nxt, p_sens_nxt, p_temp_nxt;
  logic signed [SW-1:0] off0_r, sens0_r, off0_nxt, sens0_nxt;
  logic signed [TW-1:0] temp_r, temp_nxt;

  always_comb begin
    dt_nxt = $signed({1'b0, raw_temperature}) - $signed({1'b0, coef.tref, 8'd0});
  end

  always_comb begin
    p_off_nxt  = $signed({1'b0, coef.tco}) * dt_r;
    p_sens_nxt = $signed({1'b0, coef.tcs}) * dt_r;
    p_temp_nxt = $signed({1'b0, coef.tempsens}) * dt_r;
  end

  always_comb begin
    off0_nxt  = $signed({8'd0, coef.off, 16'd0}) + SW'(p_off_r >>> 7);
    sens0_nxt = $signed({9'd0, coef.sens, 15'd0}) + SW'(p_sens_r >>> 8);
    temp_nxt  = TW'(p_temp_r >>> 23) + baro_ptc_pkg::TEMP_REF;
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      d1_s1_r <= raw_pressure;
      dt_r    <= dt_nxt;
    end
    if (en[1]) begin
      d1_s2_r  <= d1_s1_r;
      p_off_r  <= p_off_nxt;
      p_sens_r <= p_sens_nxt;
      p_temp_r <= p_temp_nxt;
    end
    if (en[2]) begin
      d1_s3_r <= d1_s2_r;
      off0_r  <= off0_nxt;
      sens0_r <= sens0_nxt;
      temp_r  <= temp_nxt;
    end
  end

  assign d1    = d1_s3_r;
  assign off0  = off0_r;
  assign sens0 = sens0_r;
  assign temp  = temp_r;

endmodule

@@ src/baro_ptc_corr.sv @@
// Stages 4-5: second-order offset and sensitivity corrections at low temperature.
// Uses baro_ptc_pkg for widths and temperature thresholds.
module baro_ptc_corr (
  input  logic                                     clk,
  input  logic [1:0]                               en,
  input  logic [baro_ptc_pkg::RAW_W-1:0]           d1_in,
  input  logic signed [baro_ptc_pkg::SUM_W-1:0]    off0,
  input  logic signed [baro_ptc_pkg::SUM_W-1:0]    sens0,
  input  logic signed [baro_ptc_pkg::TEMP_W-1:0]   temp_in,
  output logic [baro_ptc_pkg::RAW_W-1:0]           d1_out,
  output logic signed [baro_ptc_pkg::SUM_W-1:0]    off,
  output logic signed [baro_ptc_pkg::SUM_W-1:0]    sens,
  output logic signed [baro_ptc_pkg::TEMP_W-1:0]   temp_out
);

  localparam int RW = baro_ptc_pkg::RAW_W;
  localparam int SW = baro_ptc_pkg::SUM_W;
  localparam int TW = baro_ptc_pkg::TEMP_W;
  localparam int QW = baro_ptc_pkg::SQ_W;

  logic signed [TW-1:0]   dd, ee;
  logic signed [2*TW-1:0] sq_d_full, sq_e_full;

  logic [RW-1:0]        d1_s4_r, d1_s5_r;
  logic signed [SW-1:0] off0_s4_r, sens0_s4_r;
  logic signed [TW-1:0] temp_s4_r, temp_s5_r;
  logic [QW-1:0]        sq_d_r, sq_e_r, sq_d_nxt, sq_e_nxt;
  logic                 lt_hi_r, lt_lo_r, lt_hi_nxt, lt_lo_nxt;

  logic [QW+2:0]        d5;
  logic [QW+2:0]        e7;
  logic [QW+3:0]        e11;
  logic [SW-1:0]        c_off1, c_sens1, c_off2, c_sens2;
  logic signed [SW-1:0] off_r, sens_r, off_nxt, sens_nxt;

  always_comb begin
    dd        = temp_in - baro_ptc_pkg::TEMP_REF;
    ee        = temp_in - baro_ptc_pkg::TEMP_LOW;
    sq_d_full = dd * dd;
    sq_e_full = ee * ee;
    sq_d_nxt  = sq_d_full[QW-1:0];
    sq_e_nxt  = sq_e_full[QW-1:0];
    lt_hi_nxt = temp_in < baro_ptc_pkg::TEMP_REF;
    lt_lo_nxt = temp_in < baro_ptc_pkg::TEMP_LOW;
  end

  // 5*d^2, 7*e^2 and 11*e^2 by shift and add (7*e^2 as 8*e^2 minus e^2)
  always_comb begin
    d5  = {1'b0, sq_d_r, 2'd0} + {3'd0, sq_d_r};
    e7  = {sq_e_r, 3'd0} - {3'd0, sq_e_r};
    e11 = {1'b0, sq_e_r, 3'd0} + {3'd0, sq_e_r, 1'b0} + {4'd0, sq_e_r};

    c_off1  = lt_hi_r ? {3'd0, d5[QW+2:1]}  : '0;
    c_sens1 = lt_hi_r ? {4'd0, d5[QW+2:2]}  : '0;
    c_off2  = lt_lo_r ? {2'd0, e7}          : '0;
    c_sens2 = lt_lo_r ? {2'd0, e11[QW+3:1]} : '0;

    off_nxt  = off0_s4_r - $signed(c_off1) - $signed(c_off2);
    sens_nxt = sens0_s4_r - $signed(c_sens1) - $signed(c_sens2);
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      d1_s4_r    <= d1_in;
      off0_s4_r  <= off0;
      sens0_s4_r <= sens0;
      temp_s4_r  <= temp_in;
      sq_d_r     <= sq_d_nxt;
      sq_e_r     <= sq_e_nxt;
      lt_hi_r    <= lt_hi_nxt;
      lt_lo_r    <= lt_lo_nxt;
    end
    if (en[1]) begin
      d1_s5_r   <= d1_s4_r;
      off_r     <= off_nxt;
      sens_r    <= sens_nxt;
      temp_s5_r <= temp_s4_r;
    end
  end

  assign d1_out   = d1_s5_r;
  assign off      = off_r;
  assign sens     = sens_r;
  assign temp_out = temp_s5_r;

endmodule

@@ src/baro_ptc_press.sv @@
// Stages 6-8: split D1*SENS product, final scaling and pressure saturation.
// Uses baro_ptc_pkg for widths and the pressure limit.
module baro_ptc_press (
  input  logic                                     clk,
  input  logic [2:0]                               en,
  input  logic [baro_ptc_pkg::RAW_W-1:0]           d1,
  input  logic signed [baro_ptc_pkg::SUM_W-1:0]    off,
  input  logic signed [baro_ptc_pkg::SUM_W-1:0]    sens,
  input  logic signed [baro_ptc_pkg::TEMP_W-1:0]   temp_in,
  output logic [baro_ptc_pkg::PRESS_W-1:0]         pressure,
  output logic signed [baro_ptc_pkg::TEMP_W-1:0]   temperature
);

  localparam int RW = baro_ptc_pkg::RAW_W;
  localparam int SW = baro_ptc_pkg::SUM_W;
  localparam int TW = baro_ptc_pkg::TEMP_W;
  localparam int PW = baro_ptc_pkg::PRESS_W;

  logic [RW+15:0]         lo_full, lo_r;
  logic signed [RW+24:0]  hi_full;
  logic signed [RW+23:0]  hi_r;
  logic signed [SW-1:0]   off_s6_r, off_s7_r;
  logic signed [TW-1:0]   temp_s6_r, temp_s7_r, temp_s8_r;

  logic [63:0]            prod;
  logic signed [42:0]     psh_r, psh_nxt;
  logic signed [43:0]     diff;
  logic [PW-1:0]          pressure_r, pressure_nxt;

  // Low 16 bits of SENS unsigned, upper 24 bits signed
  always_comb begin
    lo_full = d1 * sens[15:0];
    hi_full = $signed({1'b0, d1}) * $signed(sens[SW-1:16]);
  end

  always_comb begin
    prod    = {hi_r, 16'd0} + {24'd0, lo_r};
    psh_nxt = $signed(prod[63:21]);
  end

  // Subtract OFF, drop 15 fraction bits, then clamp to the pressure range
  always_comb begin
    diff = $signed({psh_r[42], psh_r}) - $signed({{4{off_s7_r[SW-1]}}, off_s7_r});
    if (diff[43]) begin
      pressure_nxt = '0;
    end else if (|diff[42:35]) begin
      pressure_nxt = baro_ptc_pkg::PRESS_MAX;
    end else begin
      pressure_nxt = diff[34:15];
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      lo_r      <= lo_full;
      hi_r      <= hi_full[RW+23:0];
      off_s6_r  <= off;
      temp_s6_r <= temp_in;
    end
    if (en[1]) begin
      psh_r     <= psh_nxt;
      off_s7_r  <= off_s6_r;
      temp_s7_r <= temp_s6_r;
    end
    if (en[2]) begin
      pressure_r <= pressure_nxt;
      temp_s8_r  <= temp_s7_r;
    end
  end

  assign pressure    = pressure_r;
  assign temperature = temp_s8_r;

endmodule

@@ tb/baro_ptc_checker.sv @@
`timescale 1ns / 1ps
// Scoreboard for the barometric compensation unit: mirrors coefficient writes,
// predicts every accepted input beat and checks output beats in order.
// Depends on baro_ptc_pkg for widths, register indexes and thresholds.
module baro_ptc_checker
  import baro_ptc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [47:0]           in_tdata,   // [23:0] raw_pressure, [47:24] raw_temperature
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [39:0]           out_tdata,  // [19:0] pressure, [38:20] temperature, [39] zero
  input  logic                  cfg_wr_en,
  input  logic [ADDR_W-1:0]     cfg_addr,
  input  logic [COEF_W-1:0]     cfg_wdata,
  output int                    fail_count,
  output int                    pending,
  output int                    results
);

  typedef struct packed {
    logic [TEMP_W-1:0]  temperature;
    logic [PRESS_W-1:0] pressure;
  } comp_beat_t;

  coef_t      coefs;
  comp_beat_t comp_q[$];
  comp_beat_t want;

  function automatic comp_beat_t compensate_pair(input coef_t c, input logic [RAW_W-1:0] d1,
                                                 input logic [RAW_W-1:0] d2);
    longint     dt;
    longint     off;
    longint     sens;
    longint     tc;
    longint     sq;
    longint     p;
    comp_beat_t r;
    dt   = longint'(d2) - (longint'(c.tref) <<< 8);
    off  = (longint'(c.off) <<< 16) + ((longint'(c.tco) * dt) >>> 7);
    sens = (longint'(c.sens) <<< 15) + ((longint'(c.tcs) * dt) >>> 8);
    tc   = TEMP_REF + ((dt * longint'(c.tempsens)) >>> 23);
    // second-order correction only touches OFF and SENS, never the reported temperature
    if (tc < TEMP_REF) begin
      sq   = tc - TEMP_REF;
      sq   = 5 * sq * sq;
      off  = off - (sq >>> 1);
      sens = sens - (sq >>> 2);
      if (tc < TEMP_LOW) begin
        sq   = tc - TEMP_LOW;
        sq   = sq * sq;
        off  = off - 7 * sq;
        sens = sens - ((11 * sq) >>> 1);
      end
    end
    p = (((longint'(d1) * sens) >>> 21) - off) >>> 15;
    if (p < 0) p = 0;
    if (p > longint'(PRESS_MAX)) p = longint'(PRESS_MAX);
    r.pressure    = p[PRESS_W-1:0];
    r.temperature = tc[TEMP_W-1:0];
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    fail_count++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      comp_q.delete();
      coefs      = '0;
      fail_count = 0;
      pending    = 0;
      results    = 0;
    end else begin
      // predict with the coefficients in force before any write at this edge
      if (in_tvalid && in_tready)
        comp_q.push_back(compensate_pair(coefs, in_tdata[RAW_W-1:0], in_tdata[2*RAW_W-1:RAW_W]));
      if (cfg_wr_en) begin
        case (cfg_addr)
          REG_SENS:     coefs.sens     = cfg_wdata;
          REG_OFF:      coefs.off      = cfg_wdata;
          REG_TCS:      coefs.tcs      = cfg_wdata;
          REG_TCO:      coefs.tco      = cfg_wdata;
          REG_TREF:     coefs.tref     = cfg_wdata;
          REG_TEMPSENS: coefs.tempsens = cfg_wdata;
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        results++;
        if (comp_q.size() == 0) begin
          report_mismatch($sformatf("beat %0d (%h) arrived with nothing pending",
                                    results, out_tdata));
        end else begin
          want = comp_q.pop_front();
          if (out_tdata[PRESS_W-1:0] !== want.pressure)
            report_mismatch($sformatf("beat %0d pressure: want %0d got %0d", results,
                                      want.pressure, out_tdata[PRESS_W-1:0]));
          if (out_tdata[PRESS_W+TEMP_W-1:PRESS_W] !== want.temperature)
            report_mismatch($sformatf("beat %0d temperature: want %0d got %0d", results,
                                      $signed(want.temperature),
                                      $signed(out_tdata[PRESS_W+TEMP_W-1:PRESS_W])));
          if (out_tdata[PRESS_W+TEMP_W] !== 1'b0)
            report_mismatch($sformatf("beat %0d pad bit is %b", results,
                                      out_tdata[PRESS_W+TEMP_W]));
        end
      end
      pending = comp_q.size();
    end
  end

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// Top of the compensation unit testbench: clock, reset, coefficient loads,
// directed and random sensor pairs, output back-pressure and the verdict.
// Depends on baro_ptc_pkg, baro_pressure_temp_compensation_unit and baro_ptc_checker.
module tb_top;
  import baro_ptc_pkg::*;

  localparam int        CLK_PERIOD   = 10;
  localparam int        CYCLE_LIMIT  = 400000;
  localparam int        RAND_PER_SET = 165;
  localparam reg_idx_t  REG_SPARE_LO = 3'd6;
  localparam reg_idx_t  REG_SPARE_HI = 3'd7;
  localparam logic [RAW_W-1:0] RAW_MAX = '1;

  typedef enum logic [1:0] {RX_FLOW, RX_COIN, RX_COMB, RX_BLOCK} rx_mode_t;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_tvalid;
  logic              in_tready;
  logic [47:0]       in_tdata;   // [23:0] raw_pressure, [47:24] raw_temperature
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [39:0]       out_tdata;  // [19:0] pressure, [38:20] temperature, [39] zero
  logic              cfg_wr_en;
  reg_idx_t          cfg_addr;
  logic [COEF_W-1:0] cfg_wdata;

  int       fail_count;
  int       pending;
  int       results;
  coef_t    cur_coefs;
  int       burst_left;
  bit       idle_on;
  int       pairs_sent;
  int       settings_run;
  longint   cycle_cnt = 0;
  rx_mode_t rx_mode = RX_FLOW;
  int       rx_tick = 0;

  always #(CLK_PERIOD / 2) clk = ~clk;

  baro_pressure_temp_compensation_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  baro_ptc_checker u_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pending    (pending),
    .results    (results)
  );

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still pending", cycle_cnt, pending);
      $display("simulation failed");
      $finish;
    end
  end

  // output back-pressure: out_tready follows one of four patterns, drawn again at random
  always @(negedge clk) begin
    rx_tick++;
    if (rx_tick % 80 == 0) rx_mode = rx_mode_t'($urandom_range(0, 3));
    case (rx_mode)
      RX_FLOW:  out_tready <= 1'b1;
      RX_COIN:  out_tready <= ($urandom_range(0, 3) != 0);
      RX_COMB:  out_tready <= ((rx_tick % 7) < 4);
      default:  out_tready <= ((rx_tick % 40) >= 12);
    endcase
  end

  // raw temp hitting compensated temp t exactly unless clamped or tempsens is 0
  function automatic logic [RAW_W-1:0] d2_at_temp(input coef_t c, input int t);
    longint num;
    longint dt;
    longint d2;
    if (c.tempsens == 0) return RAW_W'($urandom);
    num = (longint'(t) - TEMP_REF) <<< 23;
    if (num <= 0) dt = -((-num) / longint'(c.tempsens));
    else          dt = (num + longint'(c.tempsens) - 1) / longint'(c.tempsens);
    d2 = (longint'(c.tref) <<< 8) + dt;
    if (d2 < 0) d2 = 0;
    if (d2 > longint'(RAW_MAX)) d2 = longint'(RAW_MAX);
    return d2[RAW_W-1:0];
  endfunction

  task automatic write_reg(input reg_idx_t idx, input logic [COEF_W-1:0] val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
  endtask

  // spare indexes go last so a stray decode would clobber a live coefficient
  task automatic load_coefs(input coef_t c);
    write_reg(REG_SENS,     c.sens);
    write_reg(REG_OFF,      c.off);
    write_reg(REG_TCS,      c.tcs);
    write_reg(REG_TCO,      c.tco);
    write_reg(REG_TREF,     c.tref);
    write_reg(REG_TEMPSENS, c.tempsens);
    write_reg(REG_SPARE_LO, COEF_W'($urandom));
    write_reg(REG_SPARE_HI, COEF_W'($urandom));
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    cur_coefs = c;
    settings_run++;
  endtask

  task automatic send_pair(input logic [RAW_W-1:0] d1, input logic [RAW_W-1:0] d2);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = idle_on ? $urandom_range(0, 10) : 0;
      if (gap > 0) begin
        @(negedge clk);
        in_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= {d2, d1};
    do @(posedge clk); while (!in_tready);
    pairs_sent++;
  endtask

  task automatic random_pairs(input int n);
    logic [RAW_W-1:0] d1;
    logic [RAW_W-1:0] d2;
    int               pick;
    idle_on = ($urandom_range(0, 3) != 0);
    repeat (n) begin
      pick = $urandom_range(0, 99);
      if (pick < 60)      d1 = RAW_W'($urandom);
      else if (pick < 90) d1 = RAW_W'($urandom_range(6000000, 12000000));
      else begin
        case ($urandom_range(0, 2))
          0:       d1 = '0;
          1:       d1 = RAW_MAX;
          default: d1 = RAW_W'($urandom_range(0, 255));
        endcase
      end
      pick = $urandom_range(0, 99);
      if (pick < 30)      d2 = RAW_W'($urandom);
      else if (pick < 70) d2 = d2_at_temp(cur_coefs, int'($urandom_range(0, 10000)) - 4000);
      else if (pick < 85) d2 = d2_at_temp(cur_coefs,
                                          int'($urandom_range(0, 20)) + int'(TEMP_REF) - 10);
      else if (pick < 95) d2 = $urandom_range(0, 1) ? RAW_W'($urandom_range(0, 255))
                                                     : RAW_MAX - RAW_W'($urandom_range(0, 255));
      else begin
        case ($urandom_range(0, 3))
          0:       d2 = d2_at_temp(cur_coefs, int'(TEMP_REF));
          1:       d2 = d2_at_temp(cur_coefs, int'(TEMP_REF) - 1);
          2:       d2 = d2_at_temp(cur_coefs, int'(TEMP_LOW));
          default: d2 = d2_at_temp(cur_coefs, int'(TEMP_LOW) - 1);
        endcase
      end
      send_pair(d1, d2);
    end
  endtask

  // drop valid and hold until every predicted beat has come out
  task automatic settle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    wait (pending == 0);
  endtask

  initial begin
    coef_t c;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    cfg_wr_en    = 1'b0;
    cfg_addr     = REG_SENS;
    cfg_wdata    = '0;
    rst_n        = 1'b0;
    burst_left   = 0;
    idle_on      = 1'b1;
    pairs_sent   = 0;
    settings_run = 1;
    cur_coefs    = '0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // coefficients straight out of reset
    send_pair('0, '0);
    send_pair(RAW_MAX, RAW_MAX);
    random_pairs(60);
    settle();

    // typical factory calibration: sens, off, tcs, tco, tref, tempsens
    load_coefs({16'd40127, 16'd36924, 16'd23317, 16'd23282, 16'd33464, 16'd28312});
    send_pair(24'd9085466, 24'd8569150);
    send_pair('0, 24'd8569150);
    send_pair(RAW_MAX, 24'd8569150);
    send_pair(24'd9085466, '0);
    send_pair(24'd9085466, RAW_MAX);
    send_pair(24'd9085466, d2_at_temp(cur_coefs, int'(TEMP_REF)));
    send_pair(24'd9085466, d2_at_temp(cur_coefs, int'(TEMP_REF) - 1));
    send_pair(24'd9085466, d2_at_temp(cur_coefs, int'(TEMP_LOW)));
    send_pair(24'd9085466, d2_at_temp(cur_coefs, int'(TEMP_LOW) - 1));
    send_pair('0, '0);
    send_pair(RAW_MAX, RAW_MAX);
    send_pair(RAW_MAX, '0);
    send_pair('0, RAW_MAX);
    send_pair(24'hAAAAAA, 24'h555555);
    send_pair(24'h555555, 24'hAAAAAA);
    random_pairs(RAND_PER_SET);
    settle();

    // every coefficient at full scale: coldest possible temperature
    load_coefs('1);
    send_pair(RAW_MAX, '0);
    send_pair('0, '0);
    send_pair(RAW_MAX, RAW_MAX);
    random_pairs(RAND_PER_SET);
    settle();

    // large sensitivity, no offset: drives pressure into the upper clamp
    load_coefs({16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF});
    send_pair(RAW_MAX, RAW_MAX);
    random_pairs(RAND_PER_SET);
    settle();

    load_coefs({6{16'd1}});
    random_pairs(RAND_PER_SET);
    settle();

    for (int k = 0; k < 4; k++) begin
      c = {$urandom, $urandom, $urandom};
      // keep half the random sets near a realistic reference temperature
      if (k[0]) c.tref = COEF_W'($urandom_range(30000, 36000));
      load_coefs(c);
      random_pairs(RAND_PER_SET);
      settle();
    end

    repeat (2 * NSTAGE) @(posedge clk);
    $display("run covered %0d sensor pairs under %0d coefficient settings",
             pairs_sent, settings_run);
    $display("%0d result beats checked, %0d mismatches", results, fail_count);
    if (fail_count == 0 && pending == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
